@@ rtl/sfbt_pkg.sv @@
// ----------------------------------------------------------------------------
// sfbt_pkg
// Shared types and constants for the step function breakpoint table.
// ----------------------------------------------------------------------------
package sfbt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_REMOVE    = 2'd1,
        REQ_LOOKUP    = 2'd2,
        REQ_TRANSLATE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REPLACE,
        CELL_REMOVE,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     cmp;
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic occ;
        logic lt;
        logic eq;
        logic gt;
        logic ovf;
    } cell_flags_t;

endpackage

@@ rtl/sfbt_cell.sv @@
// ----------------------------------------------------------------------------
// sfbt_cell
// One breakpoint slot: compares against the request, shifts with neighbors.
// ----------------------------------------------------------------------------
module sfbt_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfbt_pkg::cell_ctrl_t              ctrl,
    input  logic                              occ,
    input  logic signed [sfbt_pkg::DATA_W-1:0] req_key,
    input  logic signed [sfbt_pkg::DATA_W-1:0] req_val,
    input  logic signed [sfbt_pkg::DATA_W-1:0] key_shift,
    input  logic signed [sfbt_pkg::DATA_W-1:0] value_shift,
    input  logic signed [sfbt_pkg::DATA_W-1:0] left_key,
    input  logic signed [sfbt_pkg::DATA_W-1:0] left_val,
    input  sfbt_pkg::cell_flags_t             left_flags,
    input  logic signed [sfbt_pkg::DATA_W-1:0] right_key,
    input  logic signed [sfbt_pkg::DATA_W-1:0] right_val,
    input  sfbt_pkg::cell_flags_t             right_flags,
    output logic signed [sfbt_pkg::DATA_W-1:0] cell_key,
    output logic signed [sfbt_pkg::DATA_W-1:0] cell_val,
    output sfbt_pkg::cell_flags_t             flags,
    output logic                              hit
);
    import sfbt_pkg::*;

    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] key_next;
    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic signed [DATA_W-1:0] key_sum;
    logic signed [DATA_W-1:0] val_sum;
    cell_flags_t              flags_reg;
    cell_flags_t              flags_next;
    logic                     key_ovf;
    logic                     val_ovf;
    logic                     le;
    logic                     right_le;

    assign key_sum = key_reg + key_shift;
    assign val_sum = val_reg + value_shift;
    assign key_ovf = (key_reg[DATA_W-1] == key_shift[DATA_W-1])
                     && (key_sum[DATA_W-1] != key_reg[DATA_W-1]);
    assign val_ovf = (val_reg[DATA_W-1] == value_shift[DATA_W-1])
                     && (val_sum[DATA_W-1] != val_reg[DATA_W-1]);

    assign le       = flags_reg.occ && !flags_reg.gt;
    assign right_le = right_flags.occ && !right_flags.gt;
    assign hit      = le && !right_le;

    always_comb
    begin
        flags_next = flags_reg;
        if (ctrl.cmp)
        begin
            flags_next.occ = occ;
            flags_next.lt  = occ && (key_reg < req_key);
            flags_next.eq  = occ && (key_reg == req_key);
            flags_next.gt  = occ && (key_reg > req_key);
            flags_next.ovf = occ && (key_ovf || val_ovf);
        end
    end

    always_comb
    begin
        key_next = key_reg;
        val_next = val_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (left_flags.gt)
                begin
                    key_next = left_key;
                    val_next = left_val;
                end
                else if (left_flags.lt && !flags_reg.lt)
                begin
                    key_next = req_key;
                    val_next = req_val;
                end
            end
            CELL_REPLACE:
            begin
                if (flags_reg.eq)
                begin
                    val_next = req_val;
                end
            end
            CELL_REMOVE:
            begin
                if (flags_reg.occ && !flags_reg.lt)
                begin
                    key_next = right_key;
                    val_next = right_val;
                end
            end
            CELL_SHIFT:
            begin
                if (flags_reg.occ)
                begin
                    key_next = key_sum;
                    val_next = val_sum;
                end
            end
            default:
            begin
                key_next = key_reg;
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign cell_key = key_reg;
    assign cell_val = val_reg;
    assign flags    = flags_reg;

endmodule

@@ rtl/step_function_breakpoint_table_unit.sv @@
// ----------------------------------------------------------------------------
// step_function_breakpoint_table_unit
// Sorted breakpoint table holding a step function, one request per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one request: insert, remove,
//   lookup or translate. Output channel (out_valid/out_stall) returns one
//   result per request with status, lookup value, max/min value and count.
//   Breakpoints live in a row of cells, one per entry; each cell compares
//   its key in parallel and trades contents with its neighbors to insert
//   or remove.
//   Sequence: a request passes the compare, apply and scan states, then
//   waits in the done state until the output register is free; the
//   max/min scan visits one cell per cycle.
//   Input: in_stall is high while an item is in work, so no new item is
//   taken until the last one is done.
//   Reset: the table is empty, no result is pending.
//   Receiver stall: the result holds in the output register; the next item
//   is taken and worked, and waits before output until the register frees.
// ----------------------------------------------------------------------------
module step_function_breakpoint_table_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic signed [sfbt_pkg::DATA_W-1:0]  key,
    input  logic signed [sfbt_pkg::DATA_W-1:0]  value,
    input  logic signed [sfbt_pkg::DATA_W-1:0]  key_shift,
    input  logic signed [sfbt_pkg::DATA_W-1:0]  value_shift,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic                                has_value,
    output logic signed [sfbt_pkg::DATA_W-1:0]  value_at_key,
    output logic signed [sfbt_pkg::DATA_W-1:0]  max_value,
    output logic signed [sfbt_pkg::DATA_W-1:0]  min_value,
    output logic [4:0]                          entry_count
);
    import sfbt_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic [IDX_W-1:0]         scan_idx_next;

    req_t                     req_reg;
    logic signed [DATA_W-1:0] req_key_reg;
    logic signed [DATA_W-1:0] req_val_reg;
    logic signed [DATA_W-1:0] key_shift_reg;
    logic signed [DATA_W-1:0] value_shift_reg;

    status_t                  res_status_reg;
    status_t                  res_status_next;
    logic                     res_has_reg;
    logic                     res_has_next;
    logic signed [DATA_W-1:0] res_at_reg;
    logic signed [DATA_W-1:0] res_at_next;
    logic signed [DATA_W-1:0] mx_reg;
    logic signed [DATA_W-1:0] mx_next;
    logic signed [DATA_W-1:0] mn_reg;
    logic signed [DATA_W-1:0] mn_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    logic                     out_has_reg;
    logic signed [DATA_W-1:0] out_at_reg;
    logic signed [DATA_W-1:0] out_mx_reg;
    logic signed [DATA_W-1:0] out_mn_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic [CNT_W+4:0]         out_count_ext;

    cell_ctrl_t               ctrl;
    logic                     load_out;
    logic                     in_take;

    logic signed [DATA_W-1:0] cell_key  [CAPACITY];
    logic signed [DATA_W-1:0] cell_val  [CAPACITY];
    cell_flags_t              cell_flags[CAPACITY];
    logic [CAPACITY-1:0]      cell_hit;
    logic [CAPACITY-1:0]      cell_occ;
    logic                     found;
    logic                     any_ovf;
    logic signed [DATA_W-1:0] look_val;
    logic signed [DATA_W-1:0] scan_val;
    logic                     scan_last;

    localparam cell_flags_t LEFT_EDGE = '{occ: 1'b1, lt: 1'b1, eq: 1'b0,
                                          gt: 1'b0, ovf: 1'b0};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] lk;
            logic signed [DATA_W-1:0] lv;
            logic signed [DATA_W-1:0] rk;
            logic signed [DATA_W-1:0] rv;
            cell_flags_t              lf;
            cell_flags_t              rf;

            assign cell_occ[g] = count_reg > CNT_W'(g);

            if (g == 0)
            begin : g_left_edge
                assign lk = cell_key[g];
                assign lv = cell_val[g];
                assign lf = LEFT_EDGE;
            end
            else
            begin : g_left
                assign lk = cell_key[g-1];
                assign lv = cell_val[g-1];
                assign lf = cell_flags[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_right_edge
                assign rk = cell_key[g];
                assign rv = cell_val[g];
                assign rf = '0;
            end
            else
            begin : g_right
                assign rk = cell_key[g+1];
                assign rv = cell_val[g+1];
                assign rf = cell_flags[g+1];
            end

            sfbt_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .occ         (cell_occ[g]),
                .req_key     (req_key_reg),
                .req_val     (req_val_reg),
                .key_shift   (key_shift_reg),
                .value_shift (value_shift_reg),
                .left_key    (lk),
                .left_val    (lv),
                .left_flags  (lf),
                .right_key   (rk),
                .right_val   (rv),
                .right_flags (rf),
                .cell_key    (cell_key[g]),
                .cell_val    (cell_val[g]),
                .flags       (cell_flags[g]),
                .hit         (cell_hit[g])
            );
        end
    endgenerate

    always_comb
    begin
        found    = 1'b0;
        any_ovf  = 1'b0;
        look_val = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            found    = found | cell_flags[j].eq;
            any_ovf  = any_ovf | cell_flags[j].ovf;
            look_val = look_val | (cell_hit[j] ? cell_val[j] : '0);
        end
    end

    assign scan_val  = cell_val[scan_idx_reg];
    assign scan_last = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg;
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        res_status_next = res_status_reg;
        res_has_next    = res_has_reg;
        res_at_next     = res_at_reg;
        mx_next         = mx_reg;
        mn_next         = mn_reg;
        ctrl.cmp        = 1'b0;
        ctrl.op         = CELL_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctrl.cmp   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                res_status_next = ST_OK;
                res_has_next    = 1'b0;
                res_at_next     = '0;
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if (found)
                        begin
                            ctrl.op = CELL_REPLACE;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.op    = CELL_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (found)
                        begin
                            ctrl.op    = CELL_REMOVE;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (cell_flags[0].occ && !cell_flags[0].gt)
                        begin
                            res_has_next = 1'b1;
                            res_at_next  = look_val;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_TRANSLATE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (any_ovf)
                        begin
                            res_status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            ctrl.op = CELL_SHIFT;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
                scan_idx_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (count_reg == '0)
                begin
                    mx_next    = '0;
                    mn_next    = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    if (scan_idx_reg == '0)
                    begin
                        mx_next = scan_val;
                        mn_next = scan_val;
                    end
                    else
                    begin
                        if (scan_val > mx_reg)
                        begin
                            mx_next = scan_val;
                        end
                        if (scan_val < mn_reg)
                        begin
                            mn_next = scan_val;
                        end
                    end
                    if (scan_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        res_status_reg <= res_status_next;
        res_has_reg    <= res_has_next;
        res_at_reg     <= res_at_next;
        mx_reg         <= mx_next;
        mn_reg         <= mn_next;
        if (in_take)
        begin
            req_reg         <= req_t'(req_type);
            req_key_reg     <= key;
            req_val_reg     <= value;
            key_shift_reg   <= key_shift;
            value_shift_reg <= value_shift;
        end
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_has_reg    <= res_has_reg;
            out_at_reg     <= res_at_reg;
            out_mx_reg     <= mx_reg;
            out_mn_reg     <= mn_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_count_ext = {5'b0, out_count_reg};

    assign in_stall     = state_reg != S_IDLE;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign has_value    = out_has_reg;
    assign value_at_key = out_at_reg;
    assign max_value    = out_mx_reg;
    assign min_value    = out_mn_reg;
    assign entry_count  = out_count_ext[4:0];

endmodule

@@ rtl/sfbt_checker.sv @@
// ----------------------------------------------------------------------------
// sfbt_checker
// Port-level checks for the step function breakpoint table.
// ----------------------------------------------------------------------------
module sfbt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [2:0]                          status,
    input  logic                                has_value,
    input  logic signed [sfbt_pkg::DATA_W-1:0]  value_at_key
);
    import sfbt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(value_at_key))
        else $error("result changed while stalled");

    a_has_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_value |-> status == ST_OK)
        else $error("lookup hit with non-ok status");

    a_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_value |-> value_at_key == '0)
        else $error("value reported without a hit");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_OVERFLOW)
        else $error("status code out of range");

endmodule

bind step_function_breakpoint_table_unit sfbt_checker u_sfbt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .has_value    (has_value),
    .value_at_key (value_at_key)
);
